// ===== sv/lpdc_pkg.sv =====
`timescale 1ns / 1ps

package lpdc_pkg;

    // sample format, fixed by the word layout
    localparam int SAMPLE_WIDTH = 16;
    localparam int RES_WIDTH    = SAMPLE_WIDTH + 1;
    localparam int NUM_CELLS    = 4;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // input word
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           block_end;
    } lpdc_smp_t;

    // result word
    typedef struct packed {
        logic signed [RES_WIDTH-1:0] filtered;
        logic                        block_end_out;
    } lpdc_res_t;

    // side data riding along the cell chain
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] dly;
        logic                           flag;
    } lpdc_aux_t;

    function automatic logic lpdc_is_pow2(input int n);
        return (n & (n - 1)) == 0;
    endfunction

endpackage

// ===== sv/lpdc_delay.sv =====
`timescale 1ns / 1ps

// Shift line of DEPTH samples, advances on shift; dout is the oldest entry.
module lpdc_delay import lpdc_pkg::*;
#(
    parameter int DEPTH = 31
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  sample_t din,
    output sample_t dout
);

    sample_t line_reg [DEPTH];

    assign dout = line_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

endmodule

// ===== sv/lpdc_div.sv =====
`timescale 1ns / 1ps

// floor(sum / LENGTH). Power of two: arithmetic shift, no stage.
// Otherwise: bias to non-negative, multiply by reciprocal, two stages.
module lpdc_div import lpdc_pkg::*;
#(
    parameter int LENGTH = 32
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          up_valid,
    output logic                                          up_stall,
    input  logic signed [SAMPLE_WIDTH+$clog2(LENGTH)-1:0] up_sum,
    input  lpdc_aux_t                                     up_aux,
    output logic                                          dn_valid,
    input  logic                                          dn_stall,
    output sample_t                                       dn_q,
    output lpdc_aux_t                                     dn_aux
);

    localparam int CL        = $clog2(LENGTH);
    localparam int SUM_WIDTH = SAMPLE_WIDTH + CL;

    if (lpdc_is_pow2(LENGTH))
    begin : g_shift
        assign dn_valid = up_valid;
        assign up_stall = dn_stall;
        assign dn_q     = sample_t'(up_sum >>> CL);
        assign dn_aux   = up_aux;
    end
    else
    begin : g_recip
        // exact for biased sums below 2^SUM_WIDTH since 2^CL >= LENGTH
        localparam int SHIFT      = SUM_WIDTH + CL;
        localparam int MW         = SUM_WIDTH + 1;
        localparam int PW         = SUM_WIDTH + MW;
        localparam longint unsigned RECIP_L =
            ((64'd1 << SHIFT) + 64'(LENGTH) - 64'd1) / 64'(LENGTH);
        localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
        localparam logic [SUM_WIDTH-1:0] BIAS =
            SUM_WIDTH'(LENGTH) << (SAMPLE_WIDTH - 1);

        logic                 s1_vld_reg;
        logic                 s2_vld_reg;
        logic                 s1_stall;
        logic                 s2_stall;
        logic [SUM_WIDTH-1:0] u_reg;
        logic [SUM_WIDTH-1:0] u_next;
        logic [PW-1:0]        prod_reg;
        logic [PW-1:0]        prod_next;
        lpdc_aux_t            aux1_reg;
        lpdc_aux_t            aux2_reg;

        assign s2_stall  = s2_vld_reg && dn_stall;
        assign s1_stall  = s1_vld_reg && s2_stall;
        assign up_stall  = s1_stall;

        assign u_next    = SUM_WIDTH'(unsigned'(up_sum)) + BIAS;
        assign prod_next = PW'(u_reg) * PW'(RECIP);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s1_vld_reg <= 1'b0;
                s2_vld_reg <= 1'b0;
            end
            else
            begin
                if (!s1_stall)
                begin
                    s1_vld_reg <= up_valid;
                end
                if (!s2_stall)
                begin
                    s2_vld_reg <= s1_vld_reg;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (up_valid && !s1_stall)
            begin
                u_reg    <= u_next;
                aux1_reg <= up_aux;
            end
            if (s1_vld_reg && !s2_stall)
            begin
                prod_reg <= prod_next;
                aux2_reg <= aux1_reg;
            end
        end

        // quotient of the biased sum; flipping the top bit removes the bias
        assign dn_valid = s2_vld_reg;
        assign dn_q     = {~prod_reg[SHIFT+SAMPLE_WIDTH-1],
                           prod_reg[SHIFT+SAMPLE_WIDTH-2 -: SAMPLE_WIDTH-1]};
        assign dn_aux   = aux2_reg;
    end

endmodule

// ===== sv/lpdc_cell.sv =====
`timescale 1ns / 1ps

// One moving-average cell: history line, running sum, divide by LENGTH.
module lpdc_cell import lpdc_pkg::*;
#(
    parameter int LENGTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_stall,
    input  sample_t   up_x,
    input  lpdc_aux_t up_aux,
    output logic      dn_valid,
    input  logic      dn_stall,
    output sample_t   dn_x,
    output lpdc_aux_t dn_aux,
    output logic      take,
    output sample_t   tap
);

    localparam int SUM_WIDTH = SAMPLE_WIDTH + $clog2(LENGTH);

    logic                        vld_reg;
    logic                        div_stall;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [SUM_WIDTH-1:0] sum_next;
    sample_t                     oldest_reg;
    lpdc_aux_t                   aux_reg;

    assign up_stall = vld_reg && div_stall;
    assign take     = up_valid && !up_stall;

    // tap is the sample LENGTH-1 words back; oldest_reg the one LENGTH back
    lpdc_delay #(
        .DEPTH (LENGTH - 1)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (take),
        .din   (up_x),
        .dout  (tap)
    );

    assign sum_next = sum_reg + SUM_WIDTH'(up_x) - SUM_WIDTH'(oldest_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= 1'b0;
            sum_reg    <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            if (!up_stall)
            begin
                vld_reg <= up_valid;
            end
            if (take)
            begin
                sum_reg    <= sum_next;
                oldest_reg <= tap;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            aux_reg <= up_aux;
        end
    end

    lpdc_div #(
        .LENGTH (LENGTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld_reg),
        .up_stall (div_stall),
        .up_sum   (sum_reg),
        .up_aux   (aux_reg),
        .dn_valid (dn_valid),
        .dn_stall (dn_stall),
        .dn_q     (dn_x),
        .dn_aux   (dn_aux)
    );

endmodule

// ===== sv/linear_phase_dc_blocker.sv =====
`timescale 1ns / 1ps

// Linear-phase DC blocker: four cascaded LENGTH-tap moving averages. Each
// result word is the input delayed by 2*LENGTH-2 words minus the fourth
// average, 17 bits signed and never saturated; block_end rides along
// untouched. Averages round toward minus infinity. While res_stall is low the
// block takes one word per clock; the pace is set by each cell's running-sum
// register, which takes one add per word. A word passes each cell's sum
// register, two extra stages per cell for the reciprocal multiply when
// LENGTH is not a power of two, and the output register. A word is taken
// while results wait as long as any stage in the chain is empty. History
// and sums reset to zero; the first words see zeros as older samples.
module linear_phase_dc_blocker import lpdc_pkg::*;
#(
    parameter int LENGTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      smp_valid,
    output logic      smp_stall,
    input  lpdc_smp_t smp_word,
    output logic      res_valid,
    input  logic      res_stall,
    output lpdc_res_t res_word
);

    // chain links: index k feeds cell k, index NUM_CELLS feeds the output
    logic      c_valid [NUM_CELLS+1];
    logic      c_stall [NUM_CELLS+1];
    sample_t   c_x     [NUM_CELLS+1];
    lpdc_aux_t c_aux   [NUM_CELLS+1];

    logic      head_take;
    sample_t   head_tap;
    sample_t   dly_out;

    logic      out_vld_reg;
    lpdc_res_t res_reg;
    lpdc_res_t res_next;

    assign c_valid[0]    = smp_valid;
    assign smp_stall     = c_stall[0];
    assign c_x[0]        = smp_word.sample;
    assign c_aux[0].dly  = dly_out;
    assign c_aux[0].flag = smp_word.block_end;

    // head cell also exports its history tap for the alignment line
    lpdc_cell #(
        .LENGTH (LENGTH)
    ) u_cell_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (c_valid[0]),
        .up_stall (c_stall[0]),
        .up_x     (c_x[0]),
        .up_aux   (c_aux[0]),
        .dn_valid (c_valid[1]),
        .dn_stall (c_stall[1]),
        .dn_x     (c_x[1]),
        .dn_aux   (c_aux[1]),
        .take     (head_take),
        .tap      (head_tap)
    );

    // second LENGTH-1 of the group-delay match; shifts with the head cell
    lpdc_delay #(
        .DEPTH (LENGTH - 1)
    ) u_align (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (head_take),
        .din   (head_tap),
        .dout  (dly_out)
    );

    for (genvar k = 1; k < NUM_CELLS; k++)
    begin : g_cell
        lpdc_cell #(
            .LENGTH (LENGTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_valid[k]),
            .up_stall (c_stall[k]),
            .up_x     (c_x[k]),
            .up_aux   (c_aux[k]),
            .dn_valid (c_valid[k+1]),
            .dn_stall (c_stall[k+1]),
            .dn_x     (c_x[k+1]),
            .dn_aux   (c_aux[k+1]),
            .take     (),
            .tap      ()
        );
    end

    // output register: delayed input minus fourth average
    assign c_stall[NUM_CELLS] = out_vld_reg && res_stall;

    always_comb
    begin
        res_next.filtered      = RES_WIDTH'(c_aux[NUM_CELLS].dly)
                               - RES_WIDTH'(c_x[NUM_CELLS]);
        res_next.block_end_out = c_aux[NUM_CELLS].flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!c_stall[NUM_CELLS])
        begin
            out_vld_reg <= c_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_valid[NUM_CELLS] && !c_stall[NUM_CELLS])
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = out_vld_reg;
    assign res_word  = res_reg;

endmodule

// ===== sv/lpdc_chk.sv =====
`timescale 1ns / 1ps

// Port-level checks; counts words in flight against chain capacity.
module lpdc_chk import lpdc_pkg::*;
#(
    parameter int LENGTH = 32
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      smp_valid,
    input logic      smp_stall,
    input logic      res_valid,
    input logic      res_stall,
    input lpdc_res_t res_word
);

    localparam int DIV_DEPTH = lpdc_is_pow2(LENGTH) ? 0 : 2;
    localparam int CAPACITY  = NUM_CELLS * (1 + DIV_DEPTH) + 1;
    localparam int CW        = $clog2(CAPACITY + 2);

    logic          in_acc;
    logic          out_acc;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign in_acc   = smp_valid && !smp_stall;
    assign out_acc  = res_valid && !res_stall;
    assign cnt_next = cnt_reg + CW'(in_acc) - CW'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> cnt_reg != '0)
        else $error("result word with nothing in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("more words in flight than the chain holds");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> !smp_stall)
        else $error("input stalled while the chain is empty");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !res_stall |-> !smp_stall)
        else $error("input stalled while output drains");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("stalled result word changed");

endmodule

bind linear_phase_dc_blocker lpdc_chk #(.LENGTH(LENGTH)) u_lpdc_chk (.*);
